FILE: rtl/dcfir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcfir_pkg
// Shared types and constants for the two-channel I/Q FIR filter: sequencer
// states, operation codes and the control bundle of the channel MAC.
// ----------------------------------------------------------------------------
package dcfir_pkg;

    // fixed field widths
    localparam int TAP_COUNT_W  = 7;
    localparam int COEF_INDEX_W = 6;

    // tap count after reset
    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 7'd64;

    // operation codes of an input beat
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_ROUND,
        S_DONE
    } t_state;

    // control of one channel multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
        logic round_en;
    } t_mac_ctrl;

endpackage
`default_nettype wire

FILE: rtl/dcfir_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcfir_mac
// One channel multiply-accumulate unit: registered product, saturating
// accumulator with the rounding offset fed through the same adder, and a
// shift plus clamp back to sample width.
// ----------------------------------------------------------------------------
module dcfir_mac #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16,
    parameter int ACC_BITS    = 38
) (
    input  wire                              i_clk,
    input  wire dcfir_pkg::t_mac_ctrl        i_ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic signed [COEF_BITS-1:0]   i_coef,
    output logic signed [SAMPLE_BITS-1:0]      o_result
);

    localparam int PW = SAMPLE_BITS + COEF_BITS;
    localparam int SH = COEF_BITS - 1;

    localparam logic signed [ACC_BITS-1:0] ACC_MAX  = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN  = ~ACC_MAX;
    localparam logic signed [ACC_BITS-1:0] HALF     =
        {{(ACC_BITS-1){1'b0}}, 1'b1} << (SH - 1);
    localparam logic signed [ACC_BITS-1:0] OUT_MAX  =
        ACC_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [ACC_BITS-1:0] OUT_MIN  = ~OUT_MAX;

    logic signed [PW-1:0]       r_prod;
    logic signed [ACC_BITS-1:0] r_acc;
    logic signed [ACC_BITS-1:0] n_acc;
    logic signed [ACC_BITS-1:0] addend;
    logic signed [ACC_BITS:0]   sum_wide;
    logic signed [ACC_BITS-1:0] sum_sat;
    logic signed [ACC_BITS-1:0] shifted;

    // shared adder: product or rounding offset, saturated at the acc limits
    always_comb begin
        addend   = i_ctrl.round_en ? HALF : ACC_BITS'(r_prod);
        sum_wide = (ACC_BITS+1)'(r_acc) + (ACC_BITS+1)'(addend);
        if (sum_wide[ACC_BITS] != sum_wide[ACC_BITS-1]) begin
            sum_sat = sum_wide[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end else begin
            sum_sat = sum_wide[ACC_BITS-1:0];
        end
        if (i_ctrl.clear) begin
            n_acc = '0;
        end else if (i_ctrl.acc_en || i_ctrl.round_en) begin
            n_acc = sum_sat;
        end else begin
            n_acc = r_acc;
        end
    end

    // product and accumulator registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_sample * i_coef;
        end
        r_acc <= n_acc;
    end

    // floor shift back to Q1.15 and clamp to sample range
    always_comb begin
        shifted = r_acc >>> SH;
        if (shifted > OUT_MAX) begin
            o_result = OUT_MAX[SAMPLE_BITS-1:0];
        end else if (shifted < OUT_MIN) begin
            o_result = OUT_MIN[SAMPLE_BITS-1:0];
        end else begin
            o_result = shifted[SAMPLE_BITS-1:0];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/dual_channel_fir_filter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_channel_fir_filter_unit
// Two-channel I/Q FIR filter with one multiply-accumulate unit per channel
// stepping through the taps under a small sequencer.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): a filter beat writes one I/Q sample
// pair into the circular delay lines and yields one output beat; a load beat
// writes one I/Q coefficient pair at i_coef_index and yields nothing.
// Output channel (o_out_valid / i_out_stall): filtered I/Q pair, rounded half
// up and saturated to the sample width.
// Config port: i_cfg_wr_en writes the tap count (0 acts as 1, values above
// MAX_TAPS act as MAX_TAPS); write it only while the filter is idle.
// Sequencing: a load beat is written in the idle state and the input stays
// ready. A filter beat stalls the input while the MAC steps one tap per
// cycle through the delay and coefficient memories (one read port each),
// plus the read, multiply, drain and rounding stages; no new beat is taken
// until the result has moved to the output register.
// Reset: a clearing pass over all MAX_TAPS entries zeroes the delay lines and
// the coefficient tables; the input is stalled during it.
// Output stall: the result waits in the output register; the next filter
// result waits in the sequencer until that register is free.
// ----------------------------------------------------------------------------
module dual_channel_fir_filter_unit #(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  wire                                         i_clk,
    input  wire                                         i_rst_n,
    // config
    input  wire                                         i_cfg_wr_en,
    input  wire logic [dcfir_pkg::TAP_COUNT_W-1:0]      i_cfg_wr_data,
    // input channel
    input  wire                                         i_in_valid,
    output logic                                        o_in_stall,
    input  wire                                         i_operation,
    input  wire logic signed [SAMPLE_BITS-1:0]          i_sample_i,
    input  wire logic signed [SAMPLE_BITS-1:0]          i_sample_q,
    input  wire logic [dcfir_pkg::COEF_INDEX_W-1:0]     i_coef_index,
    input  wire logic signed [COEF_BITS-1:0]            i_coef_i,
    input  wire logic signed [COEF_BITS-1:0]            i_coef_q,
    // output channel
    output logic                                        o_out_valid,
    input  wire                                         i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]               o_out_i,
    output logic signed [SAMPLE_BITS-1:0]               o_out_q
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int PW    = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W = (PW + AW > 64) ? 64 : PW + AW;
    localparam int TC_W  = ($clog2(MAX_TAPS + 1) > dcfir_pkg::TAP_COUNT_W) ?
                           $clog2(MAX_TAPS + 1) : dcfir_pkg::TAP_COUNT_W;
    localparam logic [AW-1:0] LAST = AW'(MAX_TAPS - 1);

    // control registers
    dcfir_pkg::t_state                  r_state, n_state;
    logic [AW-1:0]                      r_clr, n_clr;
    logic [AW-1:0]                      r_wp, n_wp;
    logic [AW-1:0]                      r_j, n_j;
    logic [AW-1:0]                      r_k, n_k;
    logic                               r_v1, n_v1;
    logic                               r_v2, n_v2;
    logic [dcfir_pkg::TAP_COUNT_W-1:0]  r_tap_count;
    logic                               r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0]      r_out_i;
    logic signed [SAMPLE_BITS-1:0]      r_out_q;

    // memories
    logic signed [SAMPLE_BITS-1:0]      r_mem_di [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0]      r_mem_dq [MAX_TAPS];
    logic signed [COEF_BITS-1:0]        r_mem_ci [MAX_TAPS];
    logic signed [COEF_BITS-1:0]        r_mem_cq [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0]      r_rd_di;
    logic signed [SAMPLE_BITS-1:0]      r_rd_dq;
    logic signed [COEF_BITS-1:0]        r_rd_ci;
    logic signed [COEF_BITS-1:0]        r_rd_cq;

    // memory write ports
    logic                               dly_we;
    logic [AW-1:0]                      dly_waddr;
    logic signed [SAMPLE_BITS-1:0]      dly_wdata_i;
    logic signed [SAMPLE_BITS-1:0]      dly_wdata_q;
    logic                               coef_we;
    logic [AW-1:0]                      coef_waddr;
    logic signed [COEF_BITS-1:0]        coef_wdata_i;
    logic signed [COEF_BITS-1:0]        coef_wdata_q;

    logic                               in_accept;
    logic                               idx_ok;
    logic                               out_load;
    logic [TC_W-1:0]                    tc_ext;
    logic [TC_W-1:0]                    taps_eff;
    logic [TC_W-1:0]                    taps_dec;
    logic [AW-1:0]                      taps_m1;
    dcfir_pkg::t_mac_ctrl               mac_ctrl;
    logic signed [SAMPLE_BITS-1:0]      res_i;
    logic signed [SAMPLE_BITS-1:0]      res_q;

    // input handshake
    assign o_in_stall = (r_state != dcfir_pkg::S_IDLE) || !i_rst_n;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign idx_ok     = 32'(i_coef_index) < 32'(MAX_TAPS);

    // effective tap count, last tap index
    always_comb begin
        tc_ext = TC_W'(r_tap_count);
        if (tc_ext == '0) begin
            taps_eff = TC_W'(1);
        end else if (tc_ext > TC_W'(MAX_TAPS)) begin
            taps_eff = TC_W'(MAX_TAPS);
        end else begin
            taps_eff = tc_ext;
        end
        taps_dec = taps_eff - TC_W'(1);
        taps_m1  = taps_dec[AW-1:0];
    end

    // sequencer: next state and controls
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_wp         = r_wp;
        n_j          = r_j;
        n_k          = r_k;
        n_v1         = r_v1;
        n_v2         = r_v1;
        dly_we       = 1'b0;
        dly_waddr    = r_wp;
        dly_wdata_i  = i_sample_i;
        dly_wdata_q  = i_sample_q;
        coef_we      = 1'b0;
        coef_waddr   = AW'(i_coef_index);
        coef_wdata_i = i_coef_i;
        coef_wdata_q = i_coef_q;
        out_load     = 1'b0;
        mac_ctrl          = '0;
        mac_ctrl.mul_en   = r_v1;
        mac_ctrl.acc_en   = r_v2;

        case (r_state)
            dcfir_pkg::S_CLEAR: begin
                dly_we       = 1'b1;
                dly_waddr    = r_clr;
                dly_wdata_i  = '0;
                dly_wdata_q  = '0;
                coef_we      = 1'b1;
                coef_waddr   = r_clr;
                coef_wdata_i = '0;
                coef_wdata_q = '0;
                n_clr        = r_clr + AW'(1);
                if (r_clr == LAST) begin
                    n_state = dcfir_pkg::S_IDLE;
                end
            end
            dcfir_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_operation == dcfir_pkg::OP_LOAD) begin
                        coef_we = idx_ok;
                    end else begin
                        dly_we         = 1'b1;
                        n_j            = r_wp;
                        n_k            = '0;
                        n_wp           = (r_wp == LAST) ? '0 : r_wp + AW'(1);
                        mac_ctrl.clear = 1'b1;
                        n_state        = dcfir_pkg::S_RUN;
                    end
                end
            end
            dcfir_pkg::S_RUN: begin
                // one tap read per cycle, delay index walks back
                n_v1 = 1'b1;
                n_j  = (r_j == '0) ? LAST : r_j - AW'(1);
                n_k  = r_k + AW'(1);
                if (r_k == taps_m1) begin
                    n_state = dcfir_pkg::S_DRAIN;
                end
            end
            dcfir_pkg::S_DRAIN: begin
                n_v1 = 1'b0;
                if (!r_v1 && !r_v2) begin
                    n_state = dcfir_pkg::S_ROUND;
                end
            end
            dcfir_pkg::S_ROUND: begin
                mac_ctrl.round_en = 1'b1;
                n_state           = dcfir_pkg::S_DONE;
            end
            dcfir_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = dcfir_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dcfir_pkg::S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dcfir_pkg::S_CLEAR;
            r_clr       <= '0;
            r_wp        <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            r_tap_count <= dcfir_pkg::TAP_COUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_wp        <= n_wp;
            r_j         <= n_j;
            r_k         <= n_k;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_tap_count <= i_cfg_wr_data;
            end
        end
    end

    // delay line memories, registered read at the walking tap
    always_ff @(posedge i_clk) begin
        if (dly_we) begin
            r_mem_di[dly_waddr] <= dly_wdata_i;
            r_mem_dq[dly_waddr] <= dly_wdata_q;
        end
        r_rd_di <= r_mem_di[r_j];
        r_rd_dq <= r_mem_dq[r_j];
    end

    // coefficient memories
    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            r_mem_ci[coef_waddr] <= coef_wdata_i;
            r_mem_cq[coef_waddr] <= coef_wdata_q;
        end
        r_rd_ci <= r_mem_ci[r_k];
        r_rd_cq <= r_mem_cq[r_k];
    end

    // per-channel mac units
    dcfir_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .ACC_BITS    (ACC_W)
    ) u_mac_i (
        .i_clk    (i_clk),
        .i_ctrl   (mac_ctrl),
        .i_sample (r_rd_di),
        .i_coef   (r_rd_ci),
        .o_result (res_i)
    );

    dcfir_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .ACC_BITS    (ACC_W)
    ) u_mac_q (
        .i_clk    (i_clk),
        .i_ctrl   (mac_ctrl),
        .i_sample (r_rd_dq),
        .i_coef   (r_rd_cq),
        .o_result (res_q)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_i <= res_i;
            r_out_q <= res_q;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_i     = r_out_i;
    assign o_out_q     = r_out_q;

    // checks
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == dcfir_pkg::S_DONE)
        else $error("output beat raised outside the done step");

    a_round_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dcfir_pkg::S_ROUND) |-> (!r_v1 && !r_v2))
        else $error("rounding started with products still in flight");

    a_read_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> $past(r_state) == dcfir_pkg::S_RUN)
        else $error("tap read valid without a run step");

endmodule
`default_nettype wire
